// File: rtl/svs_pkg.sv
// shared constants and types for the two-axis s-curve velocity shaper
`default_nettype none

package svs_pkg;

   // speed, acceleration and target format
   localparam int SPEED_FRAC_BITS = 16;
   localparam int SPEED_W         = 32;
   localparam int ERR_W           = SPEED_W + 1;

   // gain and time step formats
   localparam int GAIN_W     = 24;
   localparam int GAIN_FRAC  = 20;
   localparam int STEP_W     = 24;
   localparam int STEP_FRAC  = 24;
   localparam int LIMIT_W    = 31;

   // shared multiplier operands: signed a, gain or time step zero-extended into b
   localparam int MUL_A_W = ERR_W;
   localparam int MUL_B_W = GAIN_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // gain-law accumulator and the rounding offsets for the gain and step products
   localparam int WORK_W = MUL_P_W + 1;
   localparam logic signed [WORK_W-1:0] ROUND_GAIN =
      WORK_W'(64'sd1 <<< (GAIN_FRAC - 1));
   localparam logic signed [WORK_W-1:0] ROUND_STEP =
      WORK_W'(64'sd1 <<< (STEP_FRAC - 1));

   // snap window: one speed unit
   localparam logic signed [ERR_W-1:0] ONE_UNIT =
      ERR_W'(64'sd1 <<< SPEED_FRAC_BITS);

   // |target| * 100 < one unit  <=>  |target| < ceil(one unit / 100)
   localparam longint NEAR_ZERO_VAL = ((64'sd1 <<< SPEED_FRAC_BITS) + 99) / 100;
   localparam logic signed [SPEED_W-1:0] NEAR_ZERO_LIM = SPEED_W'(NEAR_ZERO_VAL);

   localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACCEL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP    = 3'd4;

   // register reset values
   localparam logic [GAIN_W-1:0]  ACCEL_GAIN_RST   = 24'd838861;
   localparam logic [GAIN_W-1:0]  BRAKE_GAIN_RST   = 24'd943718;
   localparam logic [GAIN_W-1:0]  DAMPING_GAIN_RST = 24'd83886;
   localparam logic [LIMIT_W-1:0] MAX_ACCEL_RST    = 31'd1310720000;
   localparam logic [STEP_W-1:0]  TIME_STEP_RST    = 24'd16777;

   // request to the shared multiplier
   typedef struct packed {
      logic                      en;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

`default_nettype wire

// File: rtl/svs_channels.sv
// valid/ready channel interfaces for tick, speed result and register writes
`default_nettype none

interface svs_req_if;
   import svs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [SPEED_W-1:0] target_speed_x;
   logic signed [SPEED_W-1:0] target_speed_y;
   modport source (output valid, action, target_speed_x, target_speed_y, input ready);
   modport sink   (input valid, action, target_speed_x, target_speed_y, output ready);
endinterface

interface svs_rsp_if;
   import svs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] out_speed_x;
   logic signed [SPEED_W-1:0] out_speed_y;
   modport source (output valid, out_speed_x, out_speed_y, input ready);
   modport sink   (input valid, out_speed_x, out_speed_y, output ready);
endinterface

interface svs_csr_if;
   import svs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/scurve_velocity_shaper_two_axis.sv
// Two-axis jerk-limited velocity shaper.
//
// Channels: req_ch takes one tick word (action, target_speed_x, target_speed_y);
// rsp_ch returns one word (out_speed_x, out_speed_y) per tick; csr_ch writes
// one of five registers (accel_gain, brake_gain, damping_gain, max_accel,
// time_step) by index, always ready, indexes above four are ignored.
// A tick with action set clears both axes and returns zero speeds.
//
// Timing: one multiplier is shared by every product. Each axis runs seven
// steps (error, gain product, damping product, difference, clamp, step
// product, integrate), x axis then y axis, and a result step loads the
// output register; a clear tick goes straight there. req_ch.ready is high
// only while the sequencer is idle, so one tick is sequenced at a time.
// The result sits in an output register: a new tick is accepted while it
// waits, and a finished tick holds in its last step until the register frees.
// Reset (synchronous, active high) zeroes speeds and accelerations, loads the
// register defaults and drops rsp_ch.valid.
`default_nettype none

module scurve_velocity_shaper_two_axis (
   input  wire logic  clock,
   input  wire logic  reset,
   svs_req_if.sink    req_ch,
   svs_rsp_if.source  rsp_ch,
   svs_csr_if.sink    csr_ch
);
   import svs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ERR, S_MG, S_MD, S_DIFF, S_ACC, S_MV, S_VEL, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [GAIN_W-1:0]  accel_gain_ff,   accel_gain_in;
   logic [GAIN_W-1:0]  brake_gain_ff,   brake_gain_in;
   logic [GAIN_W-1:0]  damping_gain_ff, damping_gain_in;
   logic [LIMIT_W-1:0] max_accel_ff,    max_accel_in;
   logic [STEP_W-1:0]  time_step_ff,    time_step_in;

   // axis state
   logic signed [SPEED_W-1:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [SPEED_W-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;

   // working registers
   logic signed [SPEED_W-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic                      axis_ff, axis_in;
   logic                      brake_ff, brake_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [WORK_W-1:0]  work_ff, work_in;
   logic signed [SPEED_W-1:0] acc_new_ff, acc_new_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   mul_req_type               mul_req;
   logic signed [MUL_P_W-1:0] mul_p;

   // datapath helpers
   logic signed [SPEED_W-1:0]   cur_tgt, cur_vel, cur_acc;
   logic                        near_zero, opposite;
   logic signed [WORK_W-GAIN_FRAC-1:0] delta;
   logic signed [WORK_W-GAIN_FRAC:0]   acc_sum;
   logic signed [WORK_W-GAIN_FRAC:0]   lim_pos, lim_neg;
   logic signed [WORK_W-1:0]    step_round;
   logic signed [WORK_W-STEP_FRAC-1:0] vel_delta;
   logic signed [WORK_W-STEP_FRAC:0]   vel_sum;
   logic signed [SPEED_W-1:0]   vel_sat;
   logic signed [ERR_W-1:0]     acc_new_ext;
   logic                        snap;
   logic                        req_take;

   svs_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (mul_p)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_speed_x = rsp_x_ff;
   assign rsp_ch.out_speed_y = rsp_y_ff;

   always_comb begin
      cur_tgt = axis_ff ? tgt_y_ff : tgt_x_ff;
      cur_vel = axis_ff ? vel_y_ff : vel_x_ff;
      cur_acc = axis_ff ? acc_y_ff : acc_x_ff;

      near_zero = (cur_tgt < NEAR_ZERO_LIM) && (cur_tgt > -NEAR_ZERO_LIM);
      opposite  = ((cur_tgt > 0) && (cur_vel < 0)) || ((cur_tgt < 0) && (cur_vel > 0));

      // round half up: add half, then floor by arithmetic shift
      delta   = work_ff[WORK_W-1:GAIN_FRAC];
      acc_sum = {{(WORK_W-GAIN_FRAC+1-SPEED_W){cur_acc[SPEED_W-1]}}, cur_acc}
                + {delta[WORK_W-GAIN_FRAC-1], delta};
      lim_pos = (WORK_W-GAIN_FRAC+1)'(max_accel_ff);
      lim_neg = -lim_pos;

      step_round = {mul_p[MUL_P_W-1], mul_p} + ROUND_STEP;
      vel_delta  = step_round[WORK_W-1:STEP_FRAC];
      vel_sum    = {{(WORK_W-STEP_FRAC+1-SPEED_W){cur_vel[SPEED_W-1]}}, cur_vel}
                   + {vel_delta[WORK_W-STEP_FRAC-1], vel_delta};
      if (vel_sum > (WORK_W-STEP_FRAC+1)'(SPEED_MAX)) begin
         vel_sat = SPEED_MAX;
      end else if (vel_sum < (WORK_W-STEP_FRAC+1)'(SPEED_MIN)) begin
         vel_sat = SPEED_MIN;
      end else begin
         vel_sat = vel_sum[SPEED_W-1:0];
      end

      acc_new_ext = {acc_new_ff[SPEED_W-1], acc_new_ff};
      snap = (err_ff < ONE_UNIT) && (err_ff > -ONE_UNIT) &&
             (acc_new_ext < ONE_UNIT) && (acc_new_ext > -ONE_UNIT);
   end

   // multiplier operand select
   always_comb begin
      mul_req = '0;
      case (state_ff)
         S_MG: begin
            mul_req.en = 1'b1;
            mul_req.a  = err_ff;
            mul_req.b  = $signed({1'b0, brake_ff ? brake_gain_ff : accel_gain_ff});
         end
         S_MD: begin
            mul_req.en = 1'b1;
            mul_req.a  = {cur_acc[SPEED_W-1], cur_acc};
            mul_req.b  = $signed({1'b0, damping_gain_ff});
         end
         S_MV: begin
            mul_req.en = 1'b1;
            mul_req.a  = acc_new_ext;
            mul_req.b  = $signed({1'b0, time_step_ff});
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      accel_gain_in   = accel_gain_ff;
      brake_gain_in   = brake_gain_ff;
      damping_gain_in = damping_gain_ff;
      max_accel_in    = max_accel_ff;
      time_step_in    = time_step_ff;
      vel_x_in        = vel_x_ff;
      vel_y_in        = vel_y_ff;
      acc_x_in        = acc_x_ff;
      acc_y_in        = acc_y_ff;
      tgt_x_in        = tgt_x_ff;
      tgt_y_in        = tgt_y_ff;
      axis_in         = axis_ff;
      brake_in        = brake_ff;
      err_in          = err_ff;
      work_in         = work_ff;
      acc_new_in      = acc_new_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ACCEL_GAIN:   accel_gain_in   = csr_ch.wdata[GAIN_W-1:0];
            CSR_BRAKE_GAIN:   brake_gain_in   = csr_ch.wdata[GAIN_W-1:0];
            CSR_DAMPING_GAIN: damping_gain_in = csr_ch.wdata[GAIN_W-1:0];
            CSR_MAX_ACCEL:    max_accel_in    = csr_ch.wdata[LIMIT_W-1:0];
            CSR_TIME_STEP:    time_step_in    = csr_ch.wdata[STEP_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               tgt_x_in = req_ch.target_speed_x;
               tgt_y_in = req_ch.target_speed_y;
               axis_in  = 1'b0;
               if (req_ch.action) begin
                  vel_x_in = '0;
                  vel_y_in = '0;
                  acc_x_in = '0;
                  acc_y_in = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_ERR;
               end
            end
         end
         S_ERR: begin
            err_in   = {cur_tgt[SPEED_W-1], cur_tgt} - {cur_vel[SPEED_W-1], cur_vel};
            brake_in = near_zero || opposite;
            state_in = S_MG;
         end
         S_MG: begin
            state_in = S_MD;
         end
         S_MD: begin
            work_in  = {mul_p[MUL_P_W-1], mul_p};
            state_in = S_DIFF;
         end
         S_DIFF: begin
            work_in  = work_ff - {mul_p[MUL_P_W-1], mul_p} + ROUND_GAIN;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (acc_sum > lim_pos) begin
               acc_new_in = lim_pos[SPEED_W-1:0];
            end else if (acc_sum < lim_neg) begin
               acc_new_in = lim_neg[SPEED_W-1:0];
            end else begin
               acc_new_in = acc_sum[SPEED_W-1:0];
            end
            state_in = S_MV;
         end
         S_MV: begin
            state_in = S_VEL;
         end
         S_VEL: begin
            if (axis_ff) begin
               vel_y_in = snap ? cur_tgt : vel_sat;
               acc_y_in = snap ? '0 : acc_new_ff;
               state_in = S_DONE;
            end else begin
               vel_x_in = snap ? cur_tgt : vel_sat;
               acc_x_in = snap ? '0 : acc_new_ff;
               axis_in  = 1'b1;
               state_in = S_ERR;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_x_in     = vel_x_ff;
               rsp_y_in     = vel_y_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         accel_gain_ff   <= ACCEL_GAIN_RST;
         brake_gain_ff   <= BRAKE_GAIN_RST;
         damping_gain_ff <= DAMPING_GAIN_RST;
         max_accel_ff    <= MAX_ACCEL_RST;
         time_step_ff    <= TIME_STEP_RST;
         vel_x_ff        <= '0;
         vel_y_ff        <= '0;
         acc_x_ff        <= '0;
         acc_y_ff        <= '0;
         axis_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         accel_gain_ff   <= accel_gain_in;
         brake_gain_ff   <= brake_gain_in;
         damping_gain_ff <= damping_gain_in;
         max_accel_ff    <= max_accel_in;
         time_step_ff    <= time_step_in;
         vel_x_ff        <= vel_x_in;
         vel_y_ff        <= vel_y_in;
         acc_x_ff        <= acc_x_in;
         acc_y_ff        <= acc_y_in;
         axis_ff         <= axis_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      tgt_x_ff   <= tgt_x_in;
      tgt_y_ff   <= tgt_y_in;
      brake_ff   <= brake_in;
      err_ff     <= err_in;
      work_ff    <= work_in;
      acc_new_ff <= acc_new_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
   end

   // clear word zeroes both axes on the next edge
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.action) |=> (vel_x_ff == '0 && vel_y_ff == '0 &&
                                       acc_x_ff == '0 && acc_y_ff == '0))
      else $error("clear word did not zero axis state");

   // an accepted word starts either the x axis or the result step
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> ((state_ff == S_ERR && !axis_ff) || state_ff == S_DONE))
      else $error("accepted word did not start the sequence");

   // a new result word is loaded only from the result step
   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ch.ready)) |->
         $past(state_ff == S_DONE))
      else $error("result word loaded outside the result step");

   // loaded result matches the stored speeds
   a_result_matches: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_x_ff == vel_x_ff && rsp_y_ff == vel_y_ff))
      else $error("result word differs from axis speeds");

endmodule

`default_nettype wire

// File: rtl/svs_mul.sv
// shared signed multiplier with registered product
`default_nettype none

module svs_mul (
   input  wire logic                                clock,
   input  wire svs_pkg::mul_req_type                mul_req,
   output logic signed [svs_pkg::MUL_P_W-1:0]       product
);
   import svs_pkg::*;

   logic signed [MUL_P_W-1:0] product_ff;
   logic signed [MUL_P_W-1:0] product_in;

   always_comb begin
      product_in = product_ff;
      if (mul_req.en) begin
         product_in = MUL_P_W'(mul_req.a * mul_req.b);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// File: bench/scurve_velocity_shaper_two_axis_tb.sv
// self-checking bench for the two-axis s-curve velocity shaper: directed, extreme and random ticks
`timescale 1ns / 1ps

module scurve_velocity_shaper_two_axis_tb;
   import svs_pkg::*;

   typedef enum logic { ACT_UPDATE = 1'b0, ACT_CLEAR = 1'b1 } tick_action_type;

   typedef struct packed {
      logic signed [31:0] speed;
      logic signed [31:0] accel;
   } axis_state_type;

   typedef struct packed {
      logic [31:0] speed_x;
      logic [31:0] speed_y;
   } speed_word_type;

   localparam int     GAIN_SHIFT   = 20;
   localparam int     STEP_SHIFT   = 24;
   localparam longint GAIN_HALF    = 64'sd1 <<< (GAIN_SHIFT - 1);
   localparam longint STEP_HALF    = 64'sd1 <<< (STEP_SHIFT - 1);
   localparam longint SPEED_TOP    = 64'sd2147483647;
   localparam longint SPEED_BOTTOM = -64'sd2147483648;
   localparam int     STALL_LIMIT  = 4000;
   localparam int     DRAIN_CYCLES = 40;

   logic clock;
   logic reset;

   svs_req_if req_ch ();
   svs_rsp_if rsp_ch ();
   svs_csr_if csr_ch ();

   scurve_velocity_shaper_two_axis dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shaper state and register copies kept alongside the block
   axis_state_type  shaper_x;
   axis_state_type  shaper_y;
   logic [23:0]  accel_gain_q;
   logic [23:0]  brake_gain_q;
   logic [23:0]  damping_gain_q;
   logic [30:0]  accel_limit_q;
   logic [23:0]  time_step_q;

   speed_word_type  expected_speeds[$];

   int gap_limit;
   int hold_cycles;
   int rsp_wait;
   int quiet_cycles;
   int mismatches;
   int ticks_sent;
   int clears_sent;
   int regs_written;
   int results_checked;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int draw_gap();
      return (gap_limit == 0) ? 0 : int'($urandom_range(0, gap_limit));
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("ERROR: %s", what);
   endtask

   // one update of one axis: damped second-order law, clamp, integrate, snap
   function automatic axis_state_type advance_axis(input axis_state_type now,
                                                   input logic signed [31:0] target);
      longint tgt, vel, acc, err, lim, gain, one, mag;
      axis_state_type nxt;
      tgt  = target;
      vel  = $signed(now.speed);
      acc  = $signed(now.accel);
      one  = 64'sd1 <<< SPEED_FRAC_BITS;
      err  = tgt - vel;
      lim  = longint'(accel_limit_q);
      gain = longint'(accel_gain_q);
      mag  = (tgt < 0) ? -tgt : tgt;
      if (mag * 100 < one || (tgt > 0 && vel < 0) || (tgt < 0 && vel > 0))
         gain = longint'(brake_gain_q);
      acc = acc + ((gain * err - longint'(damping_gain_q) * acc + GAIN_HALF) >>> GAIN_SHIFT);
      if (acc > lim)
         acc = lim;
      if (acc < -lim)
         acc = -lim;
      vel = vel + ((acc * longint'(time_step_q) + STEP_HALF) >>> STEP_SHIFT);
      if (vel > SPEED_TOP)
         vel = SPEED_TOP;
      if (vel < SPEED_BOTTOM)
         vel = SPEED_BOTTOM;
      if (((err < 0) ? -err : err) < one && ((acc < 0) ? -acc : acc) < one) begin
         vel = tgt;
         acc = 0;
      end
      nxt.speed = vel[31:0];
      nxt.accel = acc[31:0];
      return nxt;
   endfunction

   task automatic send_tick(input tick_action_type act, input logic signed [31:0] tx,
                            input logic signed [31:0] ty);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.action         <= act;
      req_ch.target_speed_x <= tx;
      req_ch.target_speed_y <= ty;
      do @(posedge clock); while (!req_ch.ready);
      if (act == ACT_CLEAR) begin
         shaper_x = '0;
         shaper_y = '0;
         clears_sent++;
      end else begin
         shaper_x = advance_axis(shaper_x, tx);
         shaper_y = advance_axis(shaper_y, ty);
      end
      expected_speeds.push_back('{speed_x: shaper_x.speed, speed_y: shaper_y.speed});
      ticks_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_ACCEL_GAIN:   accel_gain_q   = data[23:0];
         CSR_BRAKE_GAIN:   brake_gain_q   = data[23:0];
         CSR_DAMPING_GAIN: damping_gain_q = data[23:0];
         CSR_MAX_ACCEL:    accel_limit_q  = data[30:0];
         CSR_TIME_STEP:    time_step_q    = data[23:0];
         default: ;
      endcase
      regs_written++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic write_reg_set(input logic [31:0] ag, input logic [31:0] bg,
                                input logic [31:0] dg, input logic [31:0] lim,
                                input logic [31:0] dt);
      write_reg(CSR_ACCEL_GAIN, ag);
      write_reg(CSR_BRAKE_GAIN, bg);
      write_reg(CSR_DAMPING_GAIN, dg);
      write_reg(CSR_MAX_ACCEL, lim);
      write_reg(CSR_TIME_STEP, dt);
   endtask

   // stop offering ticks and let every outstanding word come back
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_speeds.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain(input logic [31:0] dflt);
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return 32'h00ff_ffff;
         2:       return dflt;
         3:       return $urandom;
         default: return $urandom_range(32'h0001_0000, 32'h0040_0000);
      endcase
   endfunction

   function automatic logic signed [31:0] pick_target(input logic signed [31:0] now);
      case ($urandom_range(0, 9))
         0:       return 32'sd0;
         // straddles the near-zero braking threshold
         1:       return int'($urandom_range(0, 1400)) - 700;
         2:       return $urandom;
         3:       return $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
         4:       return -now;
         // close to the current speed, so the axis can snap
         5:       return now + int'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
         default: return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      endcase
   endfunction

   task automatic test_defaults_directed();
      gap_limit = 17;
      send_tick(ACT_UPDATE, 32'sd0, 32'sd0);
      send_tick(ACT_UPDATE, 32'sh0000_8000, -32'sh0000_8000);
      send_tick(ACT_UPDATE, SPEED_MAX, SPEED_MIN);
      send_tick(ACT_UPDATE, SPEED_MAX, SPEED_MIN);
      // reversal on both axes selects the brake gain
      send_tick(ACT_UPDATE, SPEED_MIN, SPEED_MAX);
      // either side of the near-zero threshold
      send_tick(ACT_UPDATE, 32'sd655, -32'sd655);
      send_tick(ACT_UPDATE, 32'sd656, -32'sd656);
      send_tick(ACT_CLEAR, SPEED_MAX, SPEED_MIN);
      send_tick(ACT_UPDATE, 32'sd1, -32'sd1);
      // error just under one unit still snaps
      send_tick(ACT_UPDATE, 32'sh0001_0000, -32'sh0001_0000);
   endtask

   task automatic test_register_extremes();
      wait_idle();
      gap_limit = 0;
      // zero limit keeps the acceleration at zero
      write_reg_set(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_tick(ACT_UPDATE, SPEED_MAX, SPEED_MIN);
      send_tick(ACT_UPDATE, 32'sh0000_8000, -32'sh0000_8000);
      send_tick(ACT_CLEAR, 32'sd0, 32'sd0);
      wait_idle();
      // full gains, limit and step drive the speeds into saturation
      write_reg_set('1, '1, '1, '1, '1);
      repeat (3) send_tick(ACT_UPDATE, SPEED_MAX, SPEED_MIN);
      repeat (2) send_tick(ACT_UPDATE, SPEED_MIN, SPEED_MAX);
      wait_idle();
      for (int i = 0; i < 3; i++)
         write_reg(CSR_IDX_W'(CSR_TIME_STEP + 1 + i), $urandom);
      send_tick(ACT_UPDATE, 32'sh0100_0000, -32'sh0100_0000);
      send_tick(ACT_UPDATE, 32'sd0, SPEED_MAX);
      wait_idle();
   endtask

   task automatic test_backpressure();
      wait_idle();
      gap_limit = 0;
      hold_cycles = 300;
      repeat (8) send_tick(ACT_UPDATE, pick_target(shaper_x.speed), pick_target(shaper_y.speed));
      wait_idle();
   endtask

   task automatic test_random_phase(input int budget, input int idle_max);
      int left, run, kind;
      logic [31:0] lim, dt;
      logic signed [31:0] tx, ty;
      wait_idle();
      case ($urandom_range(0, 7))
         0:       lim = 32'd0;
         1:       lim = 32'h7fff_ffff;
         2:       lim = 32'd1310720000;
         3:       lim = $urandom;
         default: lim = $urandom_range(32'h0001_0000, 32'h1000_0000);
      endcase
      case ($urandom_range(0, 7))
         0:       dt = 32'd0;
         1:       dt = 32'h00ff_ffff;
         2:       dt = 32'd16777;
         3:       dt = $urandom;
         default: dt = $urandom_range(32'h0001_0000, 32'h00ff_ffff);
      endcase
      write_reg_set(pick_gain(32'd838861), pick_gain(32'd943718), pick_gain(32'd83886), lim, dt);
      gap_limit = idle_max;
      left = budget;
      while (left > 0) begin
         kind = $urandom_range(0, 15);
         tx = pick_target(shaper_x.speed);
         ty = pick_target(shaper_y.speed);
         run = (kind < 3) ? $urandom_range(1, 3) : $urandom_range(3, 30);
         while (run > 0 && left > 0) begin
            if (kind == 0)
               send_tick(ACT_CLEAR, $urandom, $urandom);
            else if (kind < 3)
               send_tick($urandom_range(0, 1) ? ACT_CLEAR : ACT_UPDATE, $urandom, $urandom);
            else
               send_tick(ACT_UPDATE, tx, ty);
            run--;
            left--;
         end
      end
   endtask

   // result side: random stalls per word, plus the long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else if (rsp_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      speed_word_type want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         results_checked++;
         rsp_wait = draw_gap();
         if (expected_speeds.size() == 0) begin
            flag_mismatch($sformatf("word %0d with nothing outstanding: x=%0d y=%0d",
                                    results_checked, rsp_ch.out_speed_x, rsp_ch.out_speed_y));
         end else begin
            want = expected_speeds.pop_front();
            if (rsp_ch.out_speed_x !== want.speed_x)
               flag_mismatch($sformatf("word %0d out_speed_x: expected %0d got %0d",
                                       results_checked, $signed(want.speed_x),
                                       rsp_ch.out_speed_x));
            if (rsp_ch.out_speed_y !== want.speed_y)
               flag_mismatch($sformatf("word %0d out_speed_y: expected %0d got %0d",
                                       results_checked, $signed(want.speed_y),
                                       rsp_ch.out_speed_y));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d words outstanding",
                     quiet_cycles, expected_speeds.size());
            $display("scurve_velocity_shaper_two_axis: mismatch");
            $finish;
         end
      end
   end

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.action         = ACT_UPDATE;
      req_ch.target_speed_x = '0;
      req_ch.target_speed_y = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = '0;
      csr_ch.wdata          = '0;
      shaper_x              = '0;
      shaper_y              = '0;
      accel_gain_q          = 24'd838861;
      brake_gain_q          = 24'd943718;
      damping_gain_q        = 24'd83886;
      accel_limit_q         = 31'd1310720000;
      time_step_q           = 24'd16777;
      gap_limit             = 0;
      hold_cycles           = 0;
      rsp_wait              = 0;
      quiet_cycles          = 0;
      mismatches            = 0;
      ticks_sent            = 0;
      clears_sent           = 0;
      regs_written          = 0;
      results_checked       = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults_directed();
      test_register_extremes();
      test_backpressure();
      for (int p = 0; p < 8; p++)
         test_random_phase(240, (p % 3 == 1) ? 0 : 17);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_speeds.size() != 0)
         flag_mismatch($sformatf("%0d speed words never arrived", expected_speeds.size()));
      $display("run covered %0d ticks (%0d clears) and %0d register writes over 11 settings",
               ticks_sent, clears_sent, regs_written);
      $display("%0d speed words compared, %0d discrepancies", results_checked, mismatches);
      if (mismatches == 0)
         $display("scurve_velocity_shaper_two_axis: match");
      else
         $display("scurve_velocity_shaper_two_axis: mismatch");
      $finish;
   end

endmodule
